/* sv/wpes_pkg.sv */
// Shared types, widths and constants of the windowed peak envelope sampler.
`timescale 1ns / 1ps
`default_nettype none
package wpes_pkg;

	// Converter and field widths
	localparam int ADC_BITS     = 12;
	localparam int TIME_W       = 32;
	localparam int COUNT_W      = 28;
	localparam int SUM_W        = COUNT_W + ADC_BITS;
	localparam int WAIT_W       = 20;
	localparam int PERIOD_W     = 20;
	localparam int SCOUNT_W     = 9;
	localparam int MARGIN_W     = 8;
	localparam int GAP_W        = 16;
	localparam int PTS_W        = 9;
	localparam int POINT_W      = 8;
	localparam int CFG_IDX_W    = 3;
	localparam int CFG_DATA_W   = 20;
	localparam int IN_TDATA_W   = 48;
	localparam int OUT_TDATA_W  = 64;

	// Defaults for the top-level parameters
	localparam int WINDOW_DEPTH_DEF = 5;
	localparam int MAX_POINTS_DEF   = 256;

	// Register reset values
	localparam logic [WAIT_W-1:0]   WAIT_TIME_RST     = WAIT_W'(15000);
	localparam logic [PERIOD_W-1:0] SAMPLE_PERIOD_RST = PERIOD_W'(100);
	localparam logic [SCOUNT_W-1:0] SAMPLE_COUNT_RST  = SCOUNT_W'(256);
	localparam logic [MARGIN_W-1:0] FLOOR_MARGIN_RST  = MARGIN_W'(10);
	localparam logic [GAP_W-1:0]    STALE_GAP_RST     = GAP_W'(50);

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WAIT_TIME     = 3'd0,
		REG_SAMPLE_PERIOD = 3'd1,
		REG_SAMPLE_COUNT  = 3'd2,
		REG_FLOOR_MARGIN  = 3'd3,
		REG_STALE_GAP     = 3'd4
	} cfg_reg_t;

	// Capture phase
	typedef enum logic [1:0] {
		PH_IDLE,
		PH_WAIT,
		PH_SAMPLE,
		PH_DONE
	} phase_t;

	// Controller sequencing state
	typedef enum logic [2:0] {
		ST_READY,
		ST_EVAL,
		ST_DIV,
		ST_SCAN,
		ST_PUSH
	} ctrl_state_t;

	// Controller to datapath commands
	typedef struct packed {
		logic latch_in;
		logic start_cap;
		logic idle_acc;
		logic ring_add;
		logic div_start;
		logic open_first;
		logic open_ivl;
		logic scan_init;
		logic scan_step;
		logic push;
	} dp_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic mode;
		logic wait_over;
		logic period_over;
		logic div_done;
		logic scan_end;
		logic fin;
		logic out_free;
	} dp_status_t;

endpackage
`default_nettype wire

/* sv/wpes_div.sv */
// Restoring divider for the idle average, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module wpes_div (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [wpes_pkg::SUM_W-1:0]    dividend,
	input  wire logic [wpes_pkg::COUNT_W-1:0]  divisor,
	output logic                               done,
	output logic [wpes_pkg::ADC_BITS-1:0]      quotient
);
	import wpes_pkg::*;

	localparam int CNT_W = $clog2(ADC_BITS + 1);

	logic                 busy_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [COUNT_W-1:0]   rem_q;
	logic [COUNT_W-1:0]   dvs_q;
	logic [ADC_BITS-1:0]  dvd_q;
	logic [ADC_BITS-1:0]  quo_q;
	logic [COUNT_W:0]     trial;
	logic                 fits;

	// Trial subtraction of the next remainder
	assign trial = {rem_q, dvd_q[ADC_BITS-1]};
	assign fits  = trial >= {1'b0, dvs_q};

	// Sequencing, cleared on reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(ADC_BITS);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// Remainder and quotient shift; the high dividend bits stay below the divisor
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend[SUM_W-1:ADC_BITS];
			dvd_q <= dividend[ADC_BITS-1:0];
			dvs_q <= divisor;
			quo_q <= '0;
		end else if (busy_q && cnt_q != '0) begin
			rem_q <= fits ? COUNT_W'(trial - {1'b0, dvs_q}) : trial[COUNT_W-1:0];
			dvd_q <= {dvd_q[ADC_BITS-2:0], 1'b0};
			quo_q <= {quo_q[ADC_BITS-2:0], fits};
		end
	end

	assign done     = busy_q && (cnt_q == '0);
	assign quotient = quo_q;

endmodule
`default_nettype wire

/* sv/wpes_dp.sv */
// Datapath: registers, idle accumulator, sample ring, peak scan and result register.
`timescale 1ns / 1ps
`default_nettype none
module wpes_dp #(
	parameter int WINDOW_DEPTH = wpes_pkg::WINDOW_DEPTH_DEF,
	parameter int MAX_POINTS   = wpes_pkg::MAX_POINTS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire wpes_pkg::dp_cmd_t                 cmd,
	output wpes_pkg::dp_status_t                   status,
	input  wire logic                              cfg_valid,
	input  wire logic [wpes_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [wpes_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  wire logic [wpes_pkg::IN_TDATA_W-1:0]   s_tdata,
	input  wire logic                              s_tuser,
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	output logic [wpes_pkg::OUT_TDATA_W-1:0]       m_tdata,
	output logic                                   m_tlast
);
	import wpes_pkg::*;

	localparam int IDX_W  = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
	localparam int FILL_W = $clog2(WINDOW_DEPTH + 1);
	localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(WINDOW_DEPTH - 1);
	localparam logic [FILL_W-1:0] FULL_FILL = FILL_W'(WINDOW_DEPTH);

	// Configuration registers
	logic [WAIT_W-1:0]   wait_time_q;
	logic [PERIOD_W-1:0] sample_period_q;
	logic [SCOUNT_W-1:0] sample_count_q;
	logic [MARGIN_W-1:0] floor_margin_q;
	logic [GAP_W-1:0]    stale_gap_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wait_time_q     <= WAIT_TIME_RST;
			sample_period_q <= SAMPLE_PERIOD_RST;
			sample_count_q  <= SAMPLE_COUNT_RST;
			floor_margin_q  <= FLOOR_MARGIN_RST;
			stale_gap_q     <= STALE_GAP_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_WAIT_TIME:     wait_time_q     <= cfg_data[WAIT_W-1:0];
				REG_SAMPLE_PERIOD: sample_period_q <= cfg_data[PERIOD_W-1:0];
				REG_SAMPLE_COUNT:  sample_count_q  <= cfg_data[SCOUNT_W-1:0];
				REG_FLOOR_MARGIN:  floor_margin_q  <= cfg_data[MARGIN_W-1:0];
				REG_STALE_GAP:     stale_gap_q     <= cfg_data[GAP_W-1:0];
				default: ;
			endcase
		end
	end

	// Latched input request
	logic                mode_q;
	logic [ADC_BITS-1:0] adc_q;
	logic [TIME_W-1:0]   ts_q;

	always_ff @(posedge clk) begin
		if (cmd.latch_in) begin
			mode_q <= s_tuser;
			adc_q  <= s_tdata[ADC_BITS-1:0];
			ts_q   <= s_tdata[ADC_BITS+TIME_W-1:ADC_BITS];
		end
	end

	// Capture state
	logic [SUM_W-1:0]    idle_sum_q;
	logic [COUNT_W-1:0]  idle_count_q;
	logic [ADC_BITS-1:0] idle_avg_q;
	logic [TIME_W-1:0]   phase_start_q;
	logic [TIME_W-1:0]   capture_start_q;
	logic [TIME_W-1:0]   last_read_q;
	logic [PTS_W-1:0]    points_q;
	logic [IDX_W-1:0]    ring_pos_q;
	logic [FILL_W-1:0]   ring_fill_q;
	logic [ADC_BITS-1:0] ring_q [WINDOW_DEPTH];
	logic [IDX_W-1:0]    scan_idx_q;
	logic [ADC_BITS-1:0] peak_q;

	// Elapsed-time compares
	logic [TIME_W-1:0] elapsed;
	logic [TIME_W-1:0] gap;
	logic              stale;

	assign elapsed = ts_q - phase_start_q;
	assign gap     = ts_q - last_read_q;
	assign stale   = gap > TIME_W'(stale_gap_q);

	// Ring write position, emptied first when an interval opens after a long gap
	logic              put_en;
	logic              put_clear;
	logic [IDX_W-1:0]  put_pos;
	logic [FILL_W-1:0] put_fill;

	assign put_en    = cmd.idle_acc | cmd.ring_add | cmd.open_ivl;
	assign put_clear = cmd.open_ivl & stale;
	assign put_pos   = put_clear ? '0 : ring_pos_q;
	assign put_fill  = put_clear ? '0 : ring_fill_q;

	// Target count, clamped to one and to the point limit
	logic [SCOUNT_W-1:0] count_lo;
	logic [PTS_W-1:0]    target;
	logic [PTS_W:0]      pts_next;

	assign count_lo = (sample_count_q == '0) ? SCOUNT_W'(1) : sample_count_q;
	assign target   = (int'(count_lo) > MAX_POINTS) ? PTS_W'(MAX_POINTS) : count_lo;
	assign pts_next = {1'b0, points_q} + 1'b1;

	// Peak floor and scan element
	logic [ADC_BITS-1:0] floor_val;
	logic [ADC_BITS-1:0] scan_val;
	logic                scan_in_fill;

	assign floor_val    = (idle_avg_q > ADC_BITS'(floor_margin_q)) ?
	                      idle_avg_q - ADC_BITS'(floor_margin_q) : '0;
	assign scan_val     = ring_q[scan_idx_q];
	assign scan_in_fill = FILL_W'(scan_idx_q) < ring_fill_q;

	// Idle average divider
	logic                div_done;
	logic [ADC_BITS-1:0] div_quot;

	wpes_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (idle_sum_q),
		.divisor  (idle_count_q),
		.done     (div_done),
		.quotient (div_quot)
	);

	// Accumulator, timestamps and point counter
	always_ff @(posedge clk) begin
		if (cmd.start_cap) begin
			idle_sum_q   <= '0;
			idle_count_q <= '0;
			idle_avg_q   <= '0;
			points_q     <= '0;
		end else begin
			if (cmd.idle_acc && idle_count_q != '1) begin
				idle_sum_q   <= idle_sum_q + SUM_W'(adc_q);
				idle_count_q <= idle_count_q + 1'b1;
			end
			if (cmd.open_first) begin
				idle_avg_q <= (idle_count_q == '0) ? '0 : div_quot;
			end
			if (cmd.push) begin
				points_q <= pts_next[PTS_W-1:0];
			end
		end
		if (cmd.start_cap || cmd.open_ivl) begin
			phase_start_q <= ts_q;
		end
		if (cmd.start_cap || cmd.open_first) begin
			capture_start_q <= ts_q;
		end
		if (cmd.start_cap || put_en) begin
			last_read_q <= ts_q;
		end
	end

	// Ring storage
	always_ff @(posedge clk) begin
		if (put_en) begin
			ring_q[put_pos] <= adc_q;
		end
	end

	// Ring position and fill
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring_pos_q  <= '0;
			ring_fill_q <= '0;
		end else if (cmd.start_cap) begin
			ring_pos_q  <= '0;
			ring_fill_q <= '0;
		end else if (put_en) begin
			ring_pos_q  <= (put_pos == LAST_IDX) ? '0 : put_pos + 1'b1;
			ring_fill_q <= (put_fill == FULL_FILL) ? put_fill : put_fill + 1'b1;
		end
	end

	// Peak scan over the ring, one entry a cycle
	always_ff @(posedge clk) begin
		if (cmd.scan_init) begin
			scan_idx_q <= '0;
			peak_q     <= floor_val;
		end else if (cmd.scan_step) begin
			scan_idx_q <= scan_idx_q + 1'b1;
			if (scan_in_fill && scan_val > peak_q) begin
				peak_q <= scan_val;
			end
		end
	end

	// Result register
	logic                m_valid_q;
	logic [POINT_W-1:0]  out_point_q;
	logic [TIME_W-1:0]   out_offset_q;
	logic [ADC_BITS-1:0] out_peak_q;
	logic [ADC_BITS-1:0] out_idle_q;
	logic                out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (cmd.push) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			out_point_q  <= points_q[POINT_W-1:0];
			out_offset_q <= phase_start_q - capture_start_q;
			out_peak_q   <= peak_q;
			out_idle_q   <= idle_avg_q;
			out_last_q   <= status.fin;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {out_idle_q, out_peak_q, out_offset_q, out_point_q};
	assign m_tlast  = out_last_q;

	// Status to the controller
	assign status.mode        = mode_q;
	assign status.wait_over   = elapsed >= TIME_W'(wait_time_q);
	assign status.period_over = elapsed >= TIME_W'(sample_period_q);
	assign status.div_done    = div_done;
	assign status.scan_end    = scan_idx_q == LAST_IDX;
	assign status.fin         = pts_next >= {1'b0, target};
	assign status.out_free    = !m_valid_q || m_tready;

endmodule
`default_nettype wire

/* sv/wpes_ctrl.sv */
// Controller: capture phase and per-request sequencing state machine.
`timescale 1ns / 1ps
`default_nettype none
module wpes_ctrl (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire wpes_pkg::dp_status_t  status,
	output wpes_pkg::dp_cmd_t          cmd
);
	import wpes_pkg::*;

	ctrl_state_t state_q, state_d;
	phase_t      phase_q, phase_d;

	// State and phase registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_READY;
			phase_q <= PH_IDLE;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
		end
	end

	// Next state and phase
	always_comb begin
		state_d = state_q;
		phase_d = phase_q;
		unique case (state_q)
			ST_READY: begin
				if (s_tvalid) state_d = ST_EVAL;
			end
			ST_EVAL: begin
				state_d = ST_READY;
				if (!status.mode) begin
					phase_d = PH_WAIT;
				end else if (phase_q == PH_WAIT && status.wait_over) begin
					state_d = ST_DIV;
				end else if (phase_q == PH_SAMPLE && status.period_over) begin
					state_d = ST_SCAN;
				end
			end
			ST_DIV: begin
				if (status.div_done) begin
					state_d = ST_READY;
					phase_d = PH_SAMPLE;
				end
			end
			ST_SCAN: begin
				if (status.scan_end) state_d = ST_PUSH;
			end
			ST_PUSH: begin
				if (status.out_free) begin
					state_d = ST_READY;
					if (status.fin) phase_d = PH_DONE;
				end
			end
			default: state_d = ST_READY;
		endcase
	end

	// Commands
	always_comb begin
		cmd      = '0;
		s_tready = 1'b0;
		unique case (state_q)
			ST_READY: begin
				s_tready     = 1'b1;
				cmd.latch_in = s_tvalid;
			end
			ST_EVAL: begin
				if (!status.mode) begin
					cmd.start_cap = 1'b1;
				end else if (phase_q == PH_WAIT) begin
					cmd.div_start = status.wait_over;
					cmd.idle_acc  = !status.wait_over;
				end else if (phase_q == PH_SAMPLE) begin
					cmd.scan_init = status.period_over;
					cmd.ring_add  = !status.period_over;
				end
			end
			ST_DIV: begin
				cmd.open_first = status.div_done;
				cmd.open_ivl   = status.div_done;
			end
			ST_SCAN: begin
				cmd.scan_step = 1'b1;
			end
			ST_PUSH: begin
				cmd.push     = status.out_free;
				cmd.open_ivl = status.out_free && !status.fin;
			end
			default: ;
		endcase
	end

endmodule
`default_nettype wire

/* sv/windowed_peak_envelope_sampler_top.sv */
// Top level of the windowed peak envelope sampler.
`timescale 1ns / 1ps
`default_nettype none
// A start request (tuser 0) opens a capture; ADC requests (tuser 1) that arrive within
// wait_time average into the idle level and fill the sample ring, and the first one past
// it fixes the idle level and opens interval 0. Each request whose timestamp reaches the
// interval end yields one result: the interval offset from the capture start and the
// peak of the ring entries and the floor (idle level minus floor_margin, clamped at 0).
// One request is handled at a time. Plain start and sample requests are accepted and then
// evaluated; the request that ends the wait also runs the 12-step restoring divider; an
// interval-closing request also runs the ring scan and waits for any previous result
// still held in the output register.
// Configuration writes are always taken and must only happen while the block is idle.
module windowed_peak_envelope_sampler_top #(
	parameter int WINDOW_DEPTH = wpes_pkg::WINDOW_DEPTH_DEF,
	parameter int MAX_POINTS   = wpes_pkg::MAX_POINTS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// configuration writes
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [wpes_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [wpes_pkg::CFG_DATA_W-1:0]   cfg_data,
	// input requests
	input  wire logic                              s_tvalid,
	output logic                                   s_tready,
	input  wire logic [wpes_pkg::IN_TDATA_W-1:0]   s_tdata,  // adc_value[11:0], timestamp[43:12], zero pad
	input  wire logic                              s_tuser,  // mode
	// results
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	output logic [wpes_pkg::OUT_TDATA_W-1:0]       m_tdata,  // point_index[7:0], time_offset[39:8],
	                                                         // peak_value[51:40], idle_level[63:52]
	output logic                                   m_tlast
);
	import wpes_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;

	assign cfg_ready = 1'b1;

	wpes_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	wpes_dp #(
		.WINDOW_DEPTH (WINDOW_DEPTH),
		.MAX_POINTS   (MAX_POINTS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

	// A result is only loaded when the output register can take it
	a_push_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |-> status.out_free)
		else $error("result loaded over a pending result");

	// One request in flight: the cycle after an accept never accepts
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("request accepted while one is in progress");

	// The divider only finishes while the block is busy
	a_div_busy: assert property (@(posedge clk) disable iff (!arst_n)
		status.div_done |-> !s_tready)
		else $error("divider finished while block ready");

endmodule
`default_nettype wire
